/* src/ip_address_rule_matcher_top_macros.svh */
// ============================================================================
// IP address rule matcher assertion macros
// Shared concurrent assertion shorthands for the rule matcher RTL.
// ============================================================================
`ifndef IP_ADDRESS_RULE_MATCHER_TOP_MACROS_SVH
`define IP_ADDRESS_RULE_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define IPARM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iparm assertion failed");

// Next-cycle implication, disabled while reset is high
`define IPARM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iparm assertion failed");

`endif

/* src/iparm_pkg.sv */
// ============================================================================
// IP address rule matcher package
// Table sizing, command codes, rule layout and sequencer states.
// ============================================================================
package iparm_pkg;

   // Table depth and derived widths
   localparam int ENTRIES = 64;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ADR_W   = 32;
   localparam int HELD_W  = 7;

   // Command codes
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // One stored rule
   typedef struct packed {
      logic [ADR_W-1:0] low;
      logic [ADR_W-1:0] high;
      logic [ADR_W-1:0] mask;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

endpackage

/* src/iparm_ram.sv */
// ============================================================================
// IP address rule matcher generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module iparm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ip_address_rule_matcher_top.sv */
// ============================================================================
// IP address rule matcher
// Mask-and-range IPv4 rule table with clear, append and lookup commands.
// ============================================================================
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  -------------------------
//  request   req_cmd, req_rule_*, req_query_addr    start high, busy low
//  response  rsp_matched, rsp_status, rsp_rules_held rsp_valid one-cycle strobe
//
// Clear, append, unused codes and lookups on an empty table: the response beat
// comes in the cycle after the request and busy stays low.
// A lookup on N held rules reads the rule RAM one entry per cycle and compares
// in one shared unit, stopping early on a hit; busy is high during the walk.
// Reset empties the table and needs no clearing pass.
// The receiver cannot stall; each response beat is shown for one cycle.
//
module ip_address_rule_matcher_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [31:0]                   req_rule_low,
   input  logic [31:0]                   req_rule_high,
   input  logic [31:0]                   req_rule_mask,
   input  logic [31:0]                   req_query_addr,
   output logic                          rsp_valid,
   output logic                          rsp_matched,
   output logic                          rsp_status,
   output logic [6:0]                    rsp_rules_held
);

   `include "ip_address_rule_matcher_top_macros.svh"

   iparm_pkg::state_type                state_ff, state_in;
   logic [iparm_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [iparm_pkg::CNT_W-1:0]         walk_idx_ff, walk_idx_in;
   logic [iparm_pkg::ADR_W-1:0]         query_ff, query_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_matched_ff, rsp_matched_in;
   logic                                rsp_status_ff, rsp_status_in;
   logic [iparm_pkg::HELD_W-1:0]        rsp_held_ff, rsp_held_in;

   logic                                accept;
   logic                                not_full;
   logic                                wr_en;
   iparm_pkg::rule_type                 wr_rule;
   logic [iparm_pkg::ADDR_W-1:0]        rd_addr;
   logic [iparm_pkg::RULE_W-1:0]        rd_data;
   iparm_pkg::rule_type                 cur_rule;
   logic [iparm_pkg::ADR_W-1:0]         masked;
   logic                                hit;

   assign accept   = start && (state_ff == iparm_pkg::ST_IDLE);
   assign not_full = (count_ff < iparm_pkg::CNT_W'(iparm_pkg::ENTRIES));
   assign wr_en    = accept && (req_cmd == iparm_pkg::CMD_APPEND) && not_full;
   assign wr_rule  = '{low: req_rule_low, high: req_rule_high, mask: req_rule_mask};

   // Read entry zero while idle so a walk starts with data in hand
   assign rd_addr = (state_ff == iparm_pkg::ST_WALK)
                    ? walk_idx_ff[iparm_pkg::ADDR_W-1:0] : '0;

   iparm_ram #(
      .WIDTH (iparm_pkg::RULE_W),
      .DEPTH (iparm_pkg::ENTRIES)
   ) u_rules (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[iparm_pkg::ADDR_W-1:0]),
      .wr_data (wr_rule),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared compare unit: masked query against the rule now out of the RAM
   assign cur_rule = iparm_pkg::rule_type'(rd_data);
   assign masked   = query_ff & cur_rule.mask;
   assign hit      = (cur_rule.high == '0) ? (masked == cur_rule.low)
                     : ((masked >= cur_rule.low) && (masked <= cur_rule.high));

   // Sequencer and response beat
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      walk_idx_in    = walk_idx_ff;
      query_in       = query_ff;
      rsp_valid_in   = 1'b0;
      rsp_matched_in = 1'b0;
      rsp_status_in  = 1'b0;
      rsp_held_in    = rsp_held_ff;
      case (state_ff)
         iparm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  iparm_pkg::CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_held_in  = '0;
                  end
                  iparm_pkg::CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (not_full) begin
                        count_in    = count_ff + 1'b1;
                        rsp_held_in = iparm_pkg::HELD_W'(count_ff + 1'b1);
                     end else begin
                        rsp_status_in = 1'b1;
                        rsp_held_in   = iparm_pkg::HELD_W'(count_ff);
                     end
                  end
                  iparm_pkg::CMD_LOOKUP: begin
                     rsp_held_in = iparm_pkg::HELD_W'(count_ff);
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        query_in    = req_query_addr;
                        walk_idx_in = iparm_pkg::CNT_W'(1);
                        state_in    = iparm_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_held_in  = iparm_pkg::HELD_W'(count_ff);
                  end
               endcase
            end
         end
         iparm_pkg::ST_WALK: begin
            // Data holds entry walk_idx-1; stop on a hit or at the last entry
            if (hit || (walk_idx_ff == count_ff)) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = hit;
               state_in       = iparm_pkg::ST_IDLE;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = iparm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iparm_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      walk_idx_ff    <= walk_idx_in;
      query_ff       <= query_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_held_ff    <= rsp_held_in;
   end

   assign busy           = (state_ff != iparm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_rules_held = rsp_held_ff;

   // Checks
   `IPARM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= iparm_pkg::CNT_W'(iparm_pkg::ENTRIES))
   `IPARM_ASSERT_IMP(a_walk_range, clock, reset, state_ff == iparm_pkg::ST_WALK,
      (walk_idx_ff != '0) && (walk_idx_ff <= count_ff))
   `IPARM_ASSERT_NXT(a_lookup_busy, clock, reset,
      accept && (req_cmd == iparm_pkg::CMD_LOOKUP) && (count_ff != '0), busy)
   `IPARM_ASSERT_IMP(a_walk_ends_beat, clock, reset,
      $fell(busy) && !$past(reset), rsp_valid)

endmodule

/* dv/ip_address_rule_matcher_top_tb.sv */
// ============================================================================
// IP address rule matcher testbench
// Drives clear, append, lookup and unused-code beats into the rule matcher.
// Each beat is scored against a local copy of the rule table or a typed-in
// response. A short directed table covers the corner cases, then random
// episodes follow. Each episode refills the table, sometimes past full, and
// looks up addresses built from the held rules. Response beats are checked
// in order, field by field.
// ============================================================================
module ip_address_rule_matcher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iparm_pkg::*;

   localparam logic [31:0] ONES        = 32'hFFFF_FFFF;
   localparam int          TOTAL_ITEMS = 1450;
   localparam int          QUIET_FROM  = 600;
   localparam int          QUIET_TO    = 900;

   // One response beat as the block reports it
   typedef struct packed {
      logic              matched;
      logic              status;
      logic [HELD_W-1:0] held;
   } rsp_beat_t;

   // One row of the directed table; fixed rows carry a typed-in response
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mk;
      logic [31:0] qa;
      bit          fixed;
      rsp_beat_t   beat;
   } stim_row_t;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic [1:0]        req_cmd        = CMD_NONE;
   logic [31:0]       req_rule_low   = '0;
   logic [31:0]       req_rule_high  = '0;
   logic [31:0]       req_rule_mask  = '0;
   logic [31:0]       req_query_addr = '0;
   logic              busy;
   logic              rsp_valid;
   logic              rsp_matched;
   logic              rsp_status;
   logic [6:0]        rsp_rules_held;

   // Typed-in response riding along with the request beat
   bit                row_fixed      = 1'b0;
   rsp_beat_t         row_beat       = '0;

   // Local copy of the rule table
   logic [31:0]       tbl_low  [ENTRIES];
   logic [31:0]       tbl_high [ENTRIES];
   logic [31:0]       tbl_mask [ENTRIES];
   int                held_rules = 0;

   // Rules the stimulus knows to be held, used to aim lookups
   logic [31:0]       aim_low [$];
   logic [31:0]       aim_high[$];
   logic [31:0]       aim_mask[$];

   rsp_beat_t         owed_replies[$];
   stim_row_t         directed_rows[$];

   int                beats_sent    = 0;
   int                fail_count    = 0;
   int                lookups_seen  = 0;
   int                hits_seen     = 0;
   int                appends_seen  = 0;
   int                drops_seen    = 0;
   int                clears_seen   = 0;

   ip_address_rule_matcher_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_rule_low   (req_rule_low),
      .req_rule_high  (req_rule_high),
      .req_rule_mask  (req_rule_mask),
      .req_query_addr (req_query_addr),
      .rsp_valid      (rsp_valid),
      .rsp_matched    (rsp_matched),
      .rsp_status     (rsp_status),
      .rsp_rules_held (rsp_rules_held)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Apply one command to the local table and return the response it owes
   function automatic rsp_beat_t rule_table_step(cmd_type c, logic [31:0] lo,
                                                 logic [31:0] hi, logic [31:0] mk,
                                                 logic [31:0] qa);
      rsp_beat_t   r;
      logic [31:0] masked;
      int          idx;
      r = '0;
      case (c)
         CMD_CLEAR: held_rules = 0;
         CMD_APPEND: begin
            if (held_rules < ENTRIES) begin
               tbl_low[held_rules]  = lo;
               tbl_high[held_rules] = hi;
               tbl_mask[held_rules] = mk;
               held_rules++;
            end else begin
               r.status = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            // Walk held rules until one hits; bounds are compared unmasked
            idx = 0;
            while (idx < held_rules && !r.matched) begin
               masked = qa & tbl_mask[idx];
               if (tbl_high[idx] == 32'd0)
                  r.matched = (masked == tbl_low[idx]);
               else
                  r.matched = (masked >= tbl_low[idx]) && (masked <= tbl_high[idx]);
               idx++;
            end
         end
         default: ;
      endcase
      r.held = held_rules[HELD_W-1:0];
      return r;
   endfunction

   function automatic stim_row_t mk_row(cmd_type c, logic [31:0] lo, logic [31:0] hi,
                                        logic [31:0] mk, logic [31:0] qa, int fixed,
                                        int m, int s, int held);
      stim_row_t row;
      row.cmd        = c;
      row.lo         = lo;
      row.hi         = hi;
      row.mk         = mk;
      row.qa         = qa;
      row.fixed      = (fixed != 0);
      row.beat.matched = m[0];
      row.beat.status  = s[0];
      row.beat.held    = held[HELD_W-1:0];
      return row;
   endfunction

   task automatic note_failure(string what, rsp_beat_t exp_beat, rsp_beat_t got_beat);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s: expected m=%0b s=%0b held=%0d, got m=%0b s=%0b held=%0d",
                  $realtime, what, exp_beat.matched, exp_beat.status, exp_beat.held,
                  got_beat.matched, got_beat.status, got_beat.held);
   endtask

   // Score response beats, then record the request beat taken at this edge
   always @(posedge clock) begin
      rsp_beat_t got_beat;
      rsp_beat_t exp_beat;
      rsp_beat_t pred_beat;
      if (!reset) begin
         if (rsp_valid) begin
            got_beat.matched = rsp_matched;
            got_beat.status  = rsp_status;
            got_beat.held    = rsp_rules_held;
            if (owed_replies.size() == 0) begin
               note_failure("response beat with nothing owed", '0, got_beat);
            end else begin
               exp_beat = owed_replies.pop_front();
               if (got_beat.matched !== exp_beat.matched ||
                   got_beat.status !== exp_beat.status ||
                   got_beat.held !== exp_beat.held)
                  note_failure("response mismatch", exp_beat, got_beat);
            end
         end
         if (start && !busy) begin
            pred_beat = rule_table_step(cmd_type'(req_cmd), req_rule_low, req_rule_high,
                                        req_rule_mask, req_query_addr);
            owed_replies.push_back(row_fixed ? row_beat : pred_beat);
            case (cmd_type'(req_cmd))
               CMD_CLEAR:  clears_seen++;
               CMD_APPEND: begin
                  appends_seen++;
                  if (pred_beat.status) drops_seen++;
               end
               CMD_LOOKUP: begin
                  lookups_seen++;
                  if (pred_beat.matched) hits_seen++;
               end
               default: ;
            endcase
         end
      end
   end

   // Present one request beat and hold it until the block takes it
   task automatic send_beat(cmd_type c, logic [31:0] lo, logic [31:0] hi,
                            logic [31:0] mk, logic [31:0] qa, bit fixed,
                            rsp_beat_t fixed_beat);
      if ((beats_sent < QUIET_FROM || beats_sent >= QUIET_TO) && $urandom_range(99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= c;
      req_rule_low   <= lo;
      req_rule_high  <= hi;
      req_rule_mask  <= mk;
      req_query_addr <= qa;
      row_fixed      <= fixed;
      row_beat       <= fixed_beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (c != CMD_NONE) beats_sent++;
   endtask

   // Hold off the sender until every owed response has arrived
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   // One refill of the table with lookups mixed in, plus some noise
   task automatic run_episode(bit force_full);
      int          appends;
      int          lookups;
      int          pick;
      int          plen;
      int          k;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mk;
      logic [31:0] qa;
      logic [31:0] span;
      if (force_full || $urandom_range(9) != 0) begin
         send_beat(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
         aim_low.delete();
         aim_high.delete();
         aim_mask.delete();
      end
      if (force_full)
         appends = ENTRIES + $urandom_range(1, 6);
      else if ($urandom_range(7) == 0)
         appends = $urandom_range(ENTRIES - 4, ENTRIES + 6);
      else
         appends = $urandom_range(1, 12);
      lookups = $urandom_range(2, 24);
      while (appends + lookups > 0) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            send_beat(CMD_NONE, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
         end else if (!force_full && pick < 5) begin
            // Break the sequence with a clear in mid-flight
            send_beat(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
            aim_low.delete();
            aim_high.delete();
            aim_mask.delete();
         end else if (appends > 0 &&
                      (lookups == 0 || $urandom_range(appends + lookups - 1) < appends)) begin
            // Build a rule: mostly prefix masks, sometimes a scattered mask
            plen = $urandom_range(0, 32);
            mk = ($urandom_range(99) < 15) ? $urandom : (ONES << (32 - plen));
            lo = ($urandom_range(9) == 0) ? $urandom : ($urandom & mk);
            case ($urandom_range(9))
               0, 1, 2, 3: hi = 32'd0;
               8:          hi = $urandom;
               9:          hi = ONES;
               default:    hi = lo + $urandom_range(0, 4095);
            endcase
            send_beat(CMD_APPEND, lo, hi, mk, $urandom, 1'b0, '0);
            if (aim_low.size() < ENTRIES) begin
               aim_low.push_back(lo);
               aim_high.push_back(hi);
               aim_mask.push_back(mk);
            end
            appends--;
         end else begin
            // Aim at a held rule: inside, on or just past its bounds
            if (aim_low.size() > 0 && $urandom_range(99) < 65) begin
               k  = $urandom_range(aim_low.size() - 1);
               lo = aim_low[k];
               hi = aim_high[k];
               mk = aim_mask[k];
               case ($urandom_range(5))
                  0: qa = lo;
                  1: qa = hi;
                  2: qa = lo - 32'd1;
                  3: qa = hi + 32'd1;
                  default: begin
                     span = hi - lo;
                     if (hi <= lo)
                        qa = lo;
                     else if (span == ONES)
                        qa = $urandom;
                     else
                        qa = lo + ($urandom % (span + 32'd1));
                  end
               endcase
               qa = (qa & mk) | ($urandom & ~mk);
            end else begin
               qa = $urandom;
            end
            send_beat(CMD_LOOKUP, $urandom, $urandom, $urandom, qa, 1'b0, '0);
            lookups--;
         end
      end
   endtask

   initial begin
      // Directed corner cases; typed-in responses only where obvious
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, ONES, 1, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_NONE, ONES, ONES, ONES, ONES, 1, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_APPEND, 32'hC0A8_0100, 0, 32'hFFFF_FF00, 0,
                                     1, 0, 0, 1));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'hC0A8_01FF, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'hC0A8_0200, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_APPEND, 32'h0A00_0000, 32'h0AFF_FFFF, ONES, 0,
                                     1, 0, 0, 2));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'h0A00_0000, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'h0AFF_FFFF, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'h0B00_0000, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'h09FF_FFFF, 0, 0, 0, 0));
      // Bounds above the mask: masked query can never reach them
      directed_rows.push_back(mk_row(CMD_APPEND, 32'h8000_0001, ONES, 32'h0000_FFFF, 0,
                                     1, 0, 0, 3));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, ONES, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_NONE, ONES, ONES, ONES, ONES, 1, 0, 0, 3));
      // Zero mask with exact zero: matches any address
      directed_rows.push_back(mk_row(CMD_APPEND, 0, 0, 0, ONES, 1, 0, 0, 4));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_LOOKUP, ONES, ONES, ONES, 32'h5A5A_5A5A,
                                     0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0));
      // Stale rules after a clear must not be read
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, ONES, 1, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_APPEND, ONES, ONES, ONES, 0, 1, 0, 0, 1));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, ONES, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(CMD_CLEAR, ONES, ONES, ONES, ONES, 1, 0, 0, 0));

      // Hold reset, then release it at a clock edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].cmd, directed_rows[i].lo, directed_rows[i].hi,
                   directed_rows[i].mk, directed_rows[i].qa, directed_rows[i].fixed,
                   directed_rows[i].beat);
      wait_drained();

      // Random episodes; the first one runs the table past full
      run_episode(1'b1);
      wait_drained();
      while (beats_sent < TOTAL_ITEMS) begin
         run_episode(1'b0);
         if ($urandom_range(4) == 0) wait_drained();
      end
      wait_drained();
      repeat (ENTRIES + 8) @(posedge clock);

      if (owed_replies.size() != 0) begin
         fail_count++;
         $display("%0d response beats never arrived", owed_replies.size());
      end
      $display("Covered %0d lookups (%0d hits), %0d appends (%0d dropped on a full table),",
               lookups_seen, hits_seen, appends_seen, drops_seen);
      $display("and %0d clears; %0d mismatched or missing response beats.",
               clears_seen, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* ip_address_rule_matcher_top.f */
+incdir+src
src/iparm_pkg.sv
src/iparm_ram.sv
src/ip_address_rule_matcher_top.sv
dv/ip_address_rule_matcher_top_tb.sv
